@@ rtl/rcpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpm_pkg
// Shared types and constants of the remote-control packet mixer.
// ----------------------------------------------------------------------------
package rcpm_pkg;

  localparam int unsigned IDLE_CNT_W_DEF = 16;
  localparam int unsigned MAX_EV         = 6;
  localparam int unsigned Q_DEPTH        = 2;
  localparam int unsigned IN_DATA_W      = 80;
  localparam int unsigned OUT_DATA_W     = 48;

  localparam logic [3:0] EXPR_NEUTRAL = 4'd1;
  localparam logic [3:0] EXPR_LOST    = 4'd12;
  localparam logic [7:0] ARM_HOME     = 8'd90;
  localparam logic [7:0] ARM_MAX      = 8'd180;
  localparam logic [6:0] CAP_SLOW     = 7'd40;
  localparam logic [6:0] CAP_MEDIUM   = 7'd70;
  localparam logic [6:0] CAP_FAST     = 7'd100;

  // configuration register indexes
  localparam logic [2:0] CFG_MAGIC      = 3'd0;
  localparam logic [2:0] CFG_TIMEOUT    = 3'd1;
  localparam logic [2:0] CFG_ESTOP_BIT  = 3'd2;
  localparam logic [2:0] CFG_CLEAR_BIT  = 3'd3;
  localparam logic [2:0] CFG_HOME_BIT   = 3'd4;
  localparam logic [2:0] CFG_UP_BIT     = 3'd5;
  localparam logic [2:0] CFG_DOWN_BIT   = 3'd6;

  typedef enum logic [2:0] {
    EV_DRIVE = 3'd0,
    EV_EXPR  = 3'd1,
    EV_ARMS  = 3'd2,
    EV_SPEED = 3'd3,
    EV_CLEAR = 3'd4,
    EV_ESTOP = 3'd5
  } ev_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AXIS,
    ST_MIX,
    ST_DIV,
    ST_EMIT
  } back_state_e;

  // one event to emit; mix marks a drive event that carries the mixed drive
  typedef struct packed {
    ev_kind_e   kind;
    logic       mix;
    logic [3:0] expr;
    logic [7:0] shoulder;
    logic [6:0] speed;
  } slot_t;

  typedef struct packed {
    slot_t [MAX_EV-1:0] slot;
    logic  [2:0]        count;
    logic  [7:0]        throttle;
    logic  [7:0]        steering;
    logic  [6:0]        cap;
  } job_t;

endpackage

@@ rtl/remote_control_packet_mixer.sv @@
`timescale 1ns / 1ps
// Path: an accepted request enters the job queue; the back end pops it and runs the
//   mix pipeline ST_AXIS, ST_MIX, ST_DIV before ST_EMIT registers the first result,
//   then one result per cycle while the receiver is ready. The single back end
//   takes a new job only once the current one is done; eventless requests skip it.
// A two-entry job queue lets the front take requests while the back end drains.
// Reset (rst_ni low, asynchronous): registers to defaults, state cleared, queue empty.
// ----------------------------------------------------------------------------
// remote_control_packet_mixer
// Remote-control packet check, failsafe timer and wheel drive mixer.
// ----------------------------------------------------------------------------
module remote_control_packet_mixer #(
  parameter int unsigned IDLE_COUNT_WIDTH = rcpm_pkg::IDLE_CNT_W_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request side
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] header_byte, [15:8] throttle, [23:16] steering, [31:24] buttons,
  // [39:32] expr_select, [47:40] speed_select, [55:48] spare_byte,
  // [63:56] check_byte, [71:64] current_left_shoulder, [75:72] current_expression
  input  logic [rcpm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] command: 0 packet, 1 timer tick
  input  logic                              s_axis_tuser,
  // result side
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [2:0] event_kind, [10:3] left_drive, [18:11] right_drive,
  // [22:19] expression_code, [30:23] left_shoulder, [38:31] right_shoulder,
  // [45:39] speed_percent
  output logic [rcpm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_idx_i,
  input  logic [15:0]                       cfg_data_i
);
  import rcpm_pkg::*;

  logic q_full, push, pop, job_valid;
  job_t job_in, job_out;

  // front: checks the packet, owns all control state, builds the event list
  rcpm_front #(
    .IDLE_COUNT_WIDTH(IDLE_COUNT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_tick_i  (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in)
  );

  rcpm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  // back: drive mixing (axis scale, clamp, cap, /100); one event per cycle when ready
  rcpm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule

@@ rtl/rcpm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpm_front
// Accepts packets and ticks, checks packets, updates control state and
// builds the event list of each request.
// ----------------------------------------------------------------------------
module rcpm_front #(
  parameter int unsigned IDLE_COUNT_WIDTH = rcpm_pkg::IDLE_CNT_W_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               in_tick_i,
  input  logic [rcpm_pkg::IN_DATA_W-1:0]     in_data_i,
  input  logic                               cfg_we_i,
  input  logic [2:0]                         cfg_idx_i,
  input  logic [15:0]                        cfg_data_i,
  input  logic                               q_full_i,
  output logic                               push_o,
  output rcpm_pkg::job_t                     job_o
);
  import rcpm_pkg::*;

  localparam int unsigned CmpW = (IDLE_COUNT_WIDTH > 16) ? IDLE_COUNT_WIDTH : 16;

  logic [7:0]  magic_q;
  logic [15:0] timeout_q;
  logic [2:0]  estop_bit_q, clear_bit_q, home_bit_q, up_bit_q, down_bit_q;

  logic                        seen_q, seen_d;
  logic                        fs_q, fs_d;
  logic [3:0]                  saved_q, saved_d;
  logic                        armv_q, armv_d;
  logic [7:0]                  shoulder_q, shoulder_d;
  logic                        latch_q, latch_d;
  logic [IDLE_COUNT_WIDTH-1:0] idle_q, idle_d;

  logic [7:0] b [8];
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i] = in_data_i[8*i +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q     <= 8'd0;
      timeout_q   <= 16'd500;
      estop_bit_q <= 3'd0;
      clear_bit_q <= 3'd1;
      home_bit_q  <= 3'd2;
      up_bit_q    <= 3'd3;
      down_bit_q  <= 3'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAGIC:     magic_q     <= cfg_data_i[7:0];
        CFG_TIMEOUT:   timeout_q   <= cfg_data_i;
        CFG_ESTOP_BIT: estop_bit_q <= cfg_data_i[2:0];
        CFG_CLEAR_BIT: clear_bit_q <= cfg_data_i[2:0];
        CFG_HOME_BIT:  home_bit_q  <= cfg_data_i[2:0];
        CFG_UP_BIT:    up_bit_q    <= cfg_data_i[2:0];
        CFG_DOWN_BIT:  down_bit_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      fs_q       <= 1'b0;
      saved_q    <= 4'd0;
      armv_q     <= 1'b0;
      shoulder_q <= ARM_HOME;
      latch_q    <= 1'b0;
      idle_q     <= '0;
    end else begin
      seen_q     <= seen_d;
      fs_q       <= fs_d;
      saved_q    <= saved_d;
      armv_q     <= armv_d;
      shoulder_q <= shoulder_d;
      latch_q    <= latch_d;
      idle_q     <= idle_d;
    end
  end

  always_comb begin
    logic [IDLE_COUNT_WIDTH-1:0] idle_inc;
    logic [CmpW-1:0]             idle_ext, tmo_ext;
    logic [7:0]                  x;
    logic [7:0]                  btns;
    logic                        latch_v, up, dn;
    logic [2:0]                  n;
    logic [6:0]                  cap;
    logic [8:0]                  base, t;
    slot_t                       s;

    seen_d     = seen_q;
    fs_d       = fs_q;
    saved_d    = saved_q;
    armv_d     = armv_q;
    shoulder_d = shoulder_q;
    latch_d    = latch_q;
    idle_d     = idle_q;
    job_o      = '0;
    s          = '0;
    n          = 3'd0;
    cap        = CAP_FAST;
    latch_v    = latch_q;
    btns       = b[3];
    up         = btns[up_bit_q];
    dn         = btns[down_bit_q];
    base       = 9'd0;
    t          = 9'd0;
    x          = b[0] ^ b[1] ^ b[2] ^ b[3] ^ b[4] ^ b[5] ^ b[6];
    idle_inc   = (idle_q != '1) ? idle_q + 1'b1 : idle_q;
    idle_ext   = CmpW'(idle_inc);
    tmo_ext    = CmpW'(timeout_q);

    if (accept) begin
      if (in_tick_i) begin
        idle_d = idle_inc;
        if (seen_q && !fs_q && (idle_ext > tmo_ext)) begin
          saved_d = (in_data_i[75:72] > EXPR_LOST) ? EXPR_LOST : in_data_i[75:72];
          s = '0; s.kind = EV_DRIVE;
          job_o.slot[n] = s; n = n + 3'd1;
          s = '0; s.kind = EV_EXPR; s.expr = EXPR_LOST;
          job_o.slot[n] = s; n = n + 3'd1;
          fs_d = 1'b1;
        end
      end else if ((b[0] == magic_q) && (x == b[7])) begin
        idle_d = '0;
        seen_d = 1'b1;
        if (fs_q) begin
          fs_d = 1'b0;
          if (saved_q != EXPR_LOST) begin
            s = '0; s.kind = EV_EXPR; s.expr = saved_q;
            job_o.slot[n] = s; n = n + 3'd1;
          end
        end
        if (btns[clear_bit_q]) begin
          s = '0; s.kind = EV_CLEAR;
          job_o.slot[n] = s; n = n + 3'd1;
          latch_v = 1'b0;
        end
        if (btns[estop_bit_q]) begin
          s = '0; s.kind = EV_DRIVE;
          job_o.slot[n] = s; n = n + 3'd1;
          if (!latch_v) begin
            s = '0; s.kind = EV_ESTOP;
            job_o.slot[n] = s; n = n + 3'd1;
            latch_v = 1'b1;
          end
        end else begin
          latch_v = 1'b0;
          case (b[5])
            8'd0:    cap = CAP_SLOW;
            8'd1:    cap = CAP_MEDIUM;
            default: cap = CAP_FAST;
          endcase
          s = '0; s.kind = EV_SPEED; s.speed = cap;
          job_o.slot[n] = s; n = n + 3'd1;
          if (btns[home_bit_q]) begin
            s = '0; s.kind = EV_DRIVE;
            job_o.slot[n] = s; n = n + 3'd1;
            shoulder_d = ARM_HOME;
            armv_d     = 1'b1;
            s = '0; s.kind = EV_ARMS; s.shoulder = ARM_HOME;
            job_o.slot[n] = s; n = n + 3'd1;
            s = '0; s.kind = EV_EXPR; s.expr = EXPR_NEUTRAL;
            job_o.slot[n] = s; n = n + 3'd1;
          end else begin
            s = '0; s.kind = EV_DRIVE; s.mix = 1'b1;
            job_o.slot[n] = s; n = n + 3'd1;
            if (b[4] >= 8'd1 && b[4] <= 8'd12) begin
              s = '0; s.kind = EV_EXPR; s.expr = 4'(b[4] - 8'd1);
              job_o.slot[n] = s; n = n + 3'd1;
            end
            if (up || dn) begin
              if (armv_q) begin
                base = {1'b0, shoulder_q};
              end else begin
                base = {1'b0, (in_data_i[71:64] > ARM_MAX) ? ARM_MAX : in_data_i[71:64]};
              end
              t = base + (up ? 9'd2 : 9'd0) - (dn ? 9'd2 : 9'd0);
              // step can leave the range by two on either side
              if (t[8]) begin
                t = 9'd0;
              end else if (t > {1'b0, ARM_MAX}) begin
                t = {1'b0, ARM_MAX};
              end
              shoulder_d = t[7:0];
              armv_d     = 1'b1;
              s = '0; s.kind = EV_ARMS; s.shoulder = t[7:0];
              job_o.slot[n] = s; n = n + 3'd1;
            end
          end
        end
        latch_d = latch_v;
      end
    end
    job_o.count    = n;
    job_o.throttle = b[1];
    job_o.steering = b[2];
    job_o.cap      = cap;
    push_o         = accept && (n != 3'd0);
  end

endmodule

@@ rtl/rcpm_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpm_fifo
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module rcpm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rcpm_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rcpm_pkg::job_t job_o
);
  import rcpm_pkg::*;

  localparam int unsigned PtrW = $clog2(Q_DEPTH);

  job_t              mem_q [Q_DEPTH];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Q_DEPTH-1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(Q_DEPTH-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (push_i ? 1'b1 : 1'b0) - (pop_i ? 1'b1 : 1'b0);
    end
  end

endmodule

@@ rtl/rcpm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpm_back
// Mixes throttle and steering into wheel drives and emits the event list.
// ----------------------------------------------------------------------------
module rcpm_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             job_valid_i,
  input  rcpm_pkg::job_t                   job_i,
  output logic                             pop_o,
  output logic                             m_valid_o,
  input  logic                             m_ready_i,
  output logic [rcpm_pkg::OUT_DATA_W-1:0]  m_data_o,
  output logic                             m_last_o
);
  import rcpm_pkg::*;

  // axis percent: above centre c*100/127 via reciprocal, below -(m*100/128)
  function automatic logic signed [7:0] axis_pct(logic [7:0] raw);
    logic [28:0] p;
    logic [14:0] m;
    if (raw[7]) begin
      p = 29'(raw[6:0]) * 29'd1651400;
      return $signed({1'b0, p[27:21]});
    end else begin
      m = 15'(9'd256 - {1'b0, raw} - 9'd128) * 15'd100;
      return -$signed({1'b0, m[13:7]});
    end
  endfunction

  function automatic logic [6:0] div100(logic [13:0] v);
    logic [27:0] p;
    p = 28'(v) * 28'd10486;
    return p[26:20];
  endfunction

  back_state_e        st_q, st_d;
  job_t               job_q, job_d;
  logic signed [7:0]  ta_q, ta_d, sa_q, sa_d;
  logic signed [15:0] lp_q, lp_d, rp_q, rp_d;
  logic signed [7:0]  ld_q, ld_d, rd_q, rd_d;
  logic [2:0]         idx_q, idx_d;
  logic               ov_q, ov_d, ol_q, ol_d;
  logic [OUT_DATA_W-1:0] od_q, od_d;

  assign m_valid_o = ov_q;
  assign m_data_o  = od_q;
  assign m_last_o  = ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      ov_q  <= 1'b0;
      idx_q <= 3'd0;
    end else begin
      st_q  <= st_d;
      ov_q  <= ov_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    ta_q  <= ta_d;
    sa_q  <= sa_d;
    lp_q  <= lp_d;
    rp_q  <= rp_d;
    ld_q  <= ld_d;
    rd_q  <= rd_d;
    od_q  <= od_d;
    ol_q  <= ol_d;
  end

  always_comb begin
    logic signed [9:0] l, r;
    logic [13:0]       la, ra;
    logic signed [7:0] capv;
    slot_t             s;
    logic [7:0]        lo, ro, rs;

    st_d  = st_q;
    job_d = job_q;
    ta_d  = ta_q;
    sa_d  = sa_q;
    lp_d  = lp_q;
    rp_d  = rp_q;
    ld_d  = ld_q;
    rd_d  = rd_q;
    idx_d = idx_q;
    od_d  = od_q;
    ol_d  = ol_q;
    ov_d  = ov_q && !m_ready_i;
    pop_o = 1'b0;
    capv  = $signed({1'b0, job_q.cap});
    l     = 10'(-ta_q) + 10'(sa_q);
    r     = 10'(-ta_q) - 10'(sa_q);
    if (l > 10'sd100)  l = 10'sd100;
    if (l < -10'sd100) l = -10'sd100;
    if (r > 10'sd100)  r = 10'sd100;
    if (r < -10'sd100) r = -10'sd100;
    la    = lp_q[15] ? 14'(-lp_q) : lp_q[13:0];
    ra    = rp_q[15] ? 14'(-rp_q) : rp_q[13:0];
    s     = job_q.slot[idx_q];
    lo    = (s.kind == EV_DRIVE && s.mix) ? ld_q : 8'd0;
    ro    = (s.kind == EV_DRIVE && s.mix) ? rd_q : 8'd0;
    rs    = (s.kind == EV_ARMS) ? ARM_MAX - s.shoulder : 8'd0;

    case (st_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          st_d  = ST_AXIS;
        end
      end
      ST_AXIS: begin
        ta_d = axis_pct(job_q.throttle);
        sa_d = axis_pct(job_q.steering);
        st_d = ST_MIX;
      end
      ST_MIX: begin
        lp_d = 16'($signed(l[7:0]) * capv);
        rp_d = 16'($signed(r[7:0]) * capv);
        st_d = ST_DIV;
      end
      ST_DIV: begin
        ld_d  = lp_q[15] ? -$signed({1'b0, div100(la)}) : $signed({1'b0, div100(la)});
        rd_d  = rp_q[15] ? -$signed({1'b0, div100(ra)}) : $signed({1'b0, div100(ra)});
        idx_d = 3'd0;
        st_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ov_q || m_ready_i) begin
          ov_d = 1'b1;
          od_d = {2'b00, s.speed, rs, s.shoulder, s.expr, ro, lo, s.kind};
          ol_d = (idx_q == job_q.count - 3'd1);
          idx_d = idx_q + 3'd1;
          if (idx_q == job_q.count - 3'd1) st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/rcpm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpm_checker
// Port-level checks of the result stream.
// ----------------------------------------------------------------------------
module rcpm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rcpm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tlast
);
  import rcpm_pkg::*;

  logic [2:0] kind;
  logic [7:0] ls, rs;
  logic [6:0] spd;

  assign kind = m_axis_tdata[2:0];
  assign ls   = m_axis_tdata[30:23];
  assign rs   = m_axis_tdata[38:31];
  assign spd  = m_axis_tdata[45:39];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && kind == EV_ARMS |-> rs == ARM_MAX - ls && ls <= ARM_MAX)
    else $error("shoulder pair does not sum to full range");

  a_noarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && kind != EV_ARMS |-> ls == 8'd0 && rs == 8'd0)
    else $error("shoulder angle on a non-arm event");

  a_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && kind == EV_SPEED |->
      spd == CAP_SLOW || spd == CAP_MEDIUM || spd == CAP_FAST)
    else $error("bad speed cap");

endmodule

bind remote_control_packet_mixer rcpm_checker u_rcpm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

@@ sim/remote_control_packet_mixer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_control_packet_mixer_test
// Drives packets and timer ticks into the packet mixer, predicts the event
// stream in a behavioral model kept alongside, and checks every event.
// ----------------------------------------------------------------------------
module remote_control_packet_mixer_test;
  import rcpm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // one event as seen on the result bus
  typedef struct packed {
    ev_kind_e    kind;
    logic [7:0]  left;
    logic [7:0]  right;
    logic [3:0]  expr;
    logic [7:0]  ls;
    logic [7:0]  rs;
    logic [6:0]  speed;
    logic        last;
  } event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = CFG_MAGIC;
  logic [15:0] cfg_data_i = '0;

  remote_control_packet_mixer dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --- mixer shadow: configuration and state ---
  logic [7:0]  magic;
  logic [15:0] timeout;
  logic [2:0]  estop_b, clear_b, home_b, up_b, down_b;
  bit          seen, in_failsafe, have_target, estop_held;
  logic [3:0]  saved_expr;
  int          target;
  int unsigned idle;

  event_t pending_events[$];
  int     fail_count = 0;
  int     cycle = 0;
  int     send_idle_pct = 0;   // chance the sender idles, percent
  int     recv_stall_pct = 0;  // chance the receiver stalls, percent
  bit     recv_hold = 1'b0;    // long receiver hold-off

  function automatic void shadow_reset();
    magic = 8'd0; timeout = 16'd500;
    estop_b = 3'd0; clear_b = 3'd1; home_b = 3'd2; up_b = 3'd3; down_b = 3'd4;
    seen = 0; in_failsafe = 0; have_target = 0; estop_held = 0;
    saved_expr = 4'd0; target = 90; idle = 0;
  endfunction

  function automatic void push_event(ev_kind_e k, int l = 0, int r = 0,
                                     int e = 0, int ls = 0, int sp = 0);
    event_t ev;
    ev.kind = k; ev.left = l[7:0]; ev.right = r[7:0]; ev.expr = e[3:0];
    ev.ls = ls[7:0]; ev.rs = (k == EV_ARMS) ? 8'(180 - ls) : 8'd0;
    ev.speed = sp[6:0]; ev.last = 1'b0;
    pending_events.push_back(ev);
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int axis_pct(logic [7:0] raw);
    int c;
    c = int'(raw) - 128;
    return c >= 0 ? (c * 100) / 127 : -(((-c) * 100) / 128);
  endfunction

  // predicted events of one request appended to pending_events
  function automatic void predict_events(bit tick, logic [IN_DATA_W-1:0] d);
    logic [7:0] b[8];
    logic [7:0] x;
    int n0, cap, thr, ste, l, r;
    n0 = pending_events.size();
    for (int i = 0; i < 8; i++) b[i] = d[8*i +: 8];
    if (tick) begin
      if (idle < 16'hFFFF) idle++;
      if (seen && !in_failsafe && idle > timeout) begin
        saved_expr = (d[75:72] > EXPR_LOST) ? EXPR_LOST : d[75:72];
        push_event(EV_DRIVE);
        push_event(EV_EXPR, 0, 0, EXPR_LOST);
        in_failsafe = 1;
      end
    end else begin
      x = 0;
      for (int i = 0; i < 7; i++) x ^= b[i];
      if (b[0] != magic || x != b[7]) return;
      idle = 0; seen = 1;
      if (in_failsafe) begin
        in_failsafe = 0;
        if (saved_expr != EXPR_LOST) push_event(EV_EXPR, 0, 0, saved_expr);
      end
      if (b[3][clear_b]) begin
        push_event(EV_CLEAR);
        estop_held = 0;
      end
      if (b[3][estop_b]) begin
        push_event(EV_DRIVE);
        if (!estop_held) begin
          push_event(EV_ESTOP);
          estop_held = 1;
        end
      end else begin
        estop_held = 0;
        cap = b[5] == 0 ? 40 : (b[5] == 1 ? 70 : 100);
        push_event(EV_SPEED, 0, 0, 0, 0, cap);
        if (b[3][home_b]) begin
          push_event(EV_DRIVE);
          target = 90; have_target = 1;
          push_event(EV_ARMS, 0, 0, 0, 90);
          push_event(EV_EXPR, 0, 0, EXPR_NEUTRAL);
        end else begin
          thr = -axis_pct(b[1]);
          ste = axis_pct(b[2]);
          l = clamp(thr + ste, -100, 100) * cap / 100;
          r = clamp(thr - ste, -100, 100) * cap / 100;
          push_event(EV_DRIVE, l, r);
          if (b[4] >= 1 && b[4] <= 12) push_event(EV_EXPR, 0, 0, b[4] - 1);
          if (b[3][up_b] || b[3][down_b]) begin
            if (!have_target) begin
              target = clamp(int'(d[71:64]), 0, 180);
              have_target = 1;
            end
            if (b[3][up_b]) target += 2;
            if (b[3][down_b]) target -= 2;
            target = clamp(target, 0, 180);
            push_event(EV_ARMS, 0, 0, 0, target);
          end
        end
      end
    end
    if (pending_events.size() > n0)
      pending_events[pending_events.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle);
    fail_count++;
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    event_t want;
    cycle <= cycle + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected event", m_axis_tdata, 0);
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tdata[2:0] != want.kind) report_mismatch("kind", m_axis_tdata[2:0], want.kind);
        if (m_axis_tdata[10:3] != want.left) report_mismatch("left", m_axis_tdata[10:3], want.left);
        if (m_axis_tdata[18:11] != want.right) report_mismatch("right", m_axis_tdata[18:11], want.right);
        if (m_axis_tdata[22:19] != want.expr) report_mismatch("expr", m_axis_tdata[22:19], want.expr);
        if (m_axis_tdata[30:23] != want.ls) report_mismatch("lshoulder", m_axis_tdata[30:23], want.ls);
        if (m_axis_tdata[38:31] != want.rs) report_mismatch("rshoulder", m_axis_tdata[38:31], want.rs);
        if (m_axis_tdata[45:39] != want.speed) report_mismatch("speed", m_axis_tdata[45:39], want.speed);
        if (m_axis_tlast != want.last) report_mismatch("last", m_axis_tlast, want.last);
      end
    end
    if (cycle >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);

  // one request: random idle gap, then hold until accepted; tvalid stays up
  // afterwards so the next request can follow without a gap
  task automatic send_request(bit tick, logic [IN_DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= tick;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_events(tick, d);
    @(negedge clk_i);
  endtask

  function automatic logic [IN_DATA_W-1:0] make_packet(logic [7:0] thr, ste, btn,
      eid, mode, logic [7:0] ls, logic [3:0] cur);
    logic [7:0] sp, ck;
    sp = 8'($urandom_range(255));
    ck = magic ^ thr ^ ste ^ btn ^ eid ^ mode ^ sp;
    return {cur, ls, ck, sp, mode, eid, btn, ste, thr, magic};
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_packet();
    logic [7:0] eid;
    eid = $urandom_range(99) < 70 ? 8'($urandom_range(13)) : 8'($urandom_range(255));
    return make_packet(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255) & $urandom_range(255)), eid,
                       8'($urandom_range(99) < 80 ? $urandom_range(3) : $urandom_range(255)),
                       8'($urandom_range(255)), 4'($urandom_range(15)));
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAGIC:     magic = val[7:0];
      CFG_TIMEOUT:   timeout = val;
      CFG_ESTOP_BIT: estop_b = val[2:0];
      CFG_CLEAR_BIT: clear_b = val[2:0];
      CFG_HOME_BIT:  home_b = val[2:0];
      CFG_UP_BIT:    up_b = val[2:0];
      default:       down_b = val[2:0];
    endcase
  endtask

  task automatic send_ticks(int n, logic [3:0] cur);
    repeat (n) send_request(1'b1, {cur, 76'($urandom())});
  endtask

  // extremes of the axes, every speed mode, buttons, broken packets
  task automatic test_directed();
    logic [IN_DATA_W-1:0] p;
    send_ticks(2, 4'd3);                       // ticks before any packet
    send_request(1'b0, make_packet(0, 255, 0, 1, 0, 0, 0));
    send_request(1'b0, make_packet(255, 0, 0, 12, 1, 0, 0));
    send_request(1'b0, make_packet(128, 128, 0, 13, 2, 0, 0));
    send_request(1'b0, make_packet(0, 0, 0, 0, 255, 0, 0));
    send_request(1'b0, make_packet(255, 255, 8'h08, 5, 2, 255, 0)); // arm up from clamp
    send_request(1'b0, make_packet(128, 128, 8'h18, 0, 2, 0, 0));   // up and down cancel
    send_request(1'b0, make_packet(128, 128, 8'h10, 0, 2, 0, 0));
    send_request(1'b0, make_packet(100, 200, 8'h04, 3, 1, 0, 0));   // home
    send_request(1'b0, make_packet(128, 128, 8'h01, 0, 2, 0, 0));   // estop
    send_request(1'b0, make_packet(0, 0, 8'h01, 0, 2, 0, 0));       // estop held
    send_request(1'b0, make_packet(0, 0, 8'h03, 0, 2, 0, 0));       // clear with estop
    send_request(1'b0, make_packet(0, 0, 8'h02, 0, 2, 0, 0));
    p = make_packet(0, 0, 0, 0, 0, 0, 0);
    p[7:0] = ~p[7:0];
    send_request(1'b0, p);                      // bad header
    p = make_packet(0, 0, 0, 0, 0, 0, 0);
    p[63:56] = ~p[63:56];
    send_request(1'b0, p);                      // bad checksum
    send_request(1'b0, 80'hFFFF_FFFF_FFFF_FFFF_FFFF);
  endtask

  // timeout into failsafe, including an out-of-range saved expression
  task automatic test_failsafe();
    write_reg(CFG_TIMEOUT, 16'd1);
    send_ticks(3, 4'd7);
    send_request(1'b0, make_packet(128, 128, 0, 0, 0, 0, 0)); // restore 7
    send_ticks(2, 4'd15);
    send_request(1'b0, make_packet(128, 128, 0, 0, 0, 0, 0)); // lost: no restore
    send_ticks(2, 4'd12);
    send_request(1'b0, random_packet());
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    send_ticks(3, 4'd0);
  endtask

  // remapped and shared button bits, extreme magic
  task automatic test_config();
    write_reg(CFG_MAGIC, 16'hFF);
    write_reg(CFG_ESTOP_BIT, 16'd7);
    write_reg(CFG_CLEAR_BIT, 16'd7);
    write_reg(CFG_HOME_BIT, 16'd6);
    write_reg(CFG_UP_BIT, 16'd0);
    write_reg(CFG_DOWN_BIT, 16'd0);
    repeat (12) send_request(1'b0, random_packet());
    write_reg(CFG_MAGIC, 16'hA5);
    write_reg(CFG_ESTOP_BIT, 16'd5);
    write_reg(CFG_CLEAR_BIT, 16'd0);
    write_reg(CFG_HOME_BIT, 16'd7);
    write_reg(CFG_UP_BIT, 16'd1);
    write_reg(CFG_DOWN_BIT, 16'd7);
    write_reg(CFG_TIMEOUT, 16'd3);
    repeat (12) send_request(1'b0, random_packet());
  endtask

  // mostly good packets with ticks and noise, under each idling mix
  task automatic test_random(int n);
    repeat (n) begin
      int r;
      r = $urandom_range(99);
      if (r < 70) send_request(1'b0, random_packet());
      else if (r < 90) send_ticks($urandom_range(1, 4), 4'($urandom_range(15)));
      else send_request(1'b0, {$urandom(), $urandom(), 16'($urandom())});
    end
  endtask

  // receiver held off long enough to back up the job queue
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(negedge clk_i);
        recv_hold = 1'b0;
      end
      begin
        repeat (10) send_request(1'b0, random_packet());
        s_axis_tvalid <= 1'b0;
      end
    join
    drain();  // sender pauses until every event is out
    repeat (5) send_request(1'b0, random_packet());
  endtask

  initial begin
    shadow_reset();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_failsafe();
    test_config();
    test_backpressure();
    test_random(45);
    send_idle_pct = 88;
    test_random(35);
    send_idle_pct = 0; recv_stall_pct = 88;
    test_random(35);
    send_idle_pct = 17; recv_stall_pct = 17;
    write_reg(CFG_TIMEOUT, 16'd2);
    test_random(35);
    drain();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
